FILE: hdl/bfe_pkg.sv
// Shared types and constants of the Bloom filter engine.
package bfe_pkg;

  localparam int unsigned STORE_BYTES = 512;
  localparam int unsigned ROW_BITS    = 32;
  localparam int unsigned ROWS        = STORE_BYTES * 8 / ROW_BITS;
  localparam int unsigned ROW_AW      = $clog2(ROWS);
  localparam int unsigned MAX_HASHES  = 16;
  localparam int unsigned HASH_WORDS  = 8;
  localparam int unsigned OFF_W       = 12;
  localparam int unsigned CNT_W       = 13;
  localparam int unsigned SIZE_W      = 10;
  localparam int unsigned HC_W        = 5;
  localparam int unsigned HIDX_W      = $clog2(MAX_HASHES);

  localparam logic [0:0] REG_SIZE   = 1'b0;
  localparam logic [0:0] REG_HASHES = 1'b1;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_TEST   = 2'd1,
    REQ_COUNT  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] hash_part_0;
    logic [63:0] hash_part_1;
    logic [63:0] hash_part_2;
    logic [63:0] hash_part_3;
  } in_item_t;

  typedef struct packed {
    logic             is_member;
    logic [CNT_W-1:0] bits_set_count;
  } out_item_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    req_e                       op;
    logic [HASH_WORDS*32-1:0]   hash;
    logic [HC_W-1:0]            n;
    logic [SIZE_W-1:0]          size;
  } cmd_t;

  typedef logic [MAX_HASHES-1:0][OFF_W-1:0] off_list_t;

endpackage

FILE: hdl/bloom_filter_engine.sv
// Bloom filter engine: front end, command queue and back end.
// Insert/test: one round of the word-serial 32x13 multiply loop and a sorted
// insertion walk per bit position, then one store row read and check for each of
// the n bit positions. Count: reads and sums ceil(size/4) 32-bit store rows, one
// at a time. One item is worked at a time.
// Reset (async, active low) clears control and the row valid bits; the store reads zero.
module bloom_filter_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bfe_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bfe_pkg::out_item_t out_item_o
);
  import bfe_pkg::*;

  logic push, full, pop, empty;
  cmd_t front_cmd, back_cmd;

  bfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .full_i     (full),
    .cmd_o      (front_cmd)
  );

  bfe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (back_cmd)
  );

  bfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (back_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: hdl/bfe_front.sv
// Front end: configuration registers, input item intake and classification.
module bfe_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bfe_pkg::in_item_t in_item_i,
  output logic             push_o,
  input  logic             full_i,
  output bfe_pkg::cmd_t    cmd_o
);
  import bfe_pkg::*;

  logic [SIZE_W-1:0] size_q;
  logic [HC_W-1:0]   hc_q;
  logic              cmd_vld_q, cmd_vld_d;
  cmd_t              cmd_q, cmd_d;
  logic              wr_en, accept;
  logic [SIZE_W-1:0] eff_size;
  logic [HC_W-1:0]   hc_clamp, n_eff;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_HASHES) ? {27'd0, hc_q} : {22'd0, size_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_W'(STORE_BYTES);
      hc_q   <= HC_W'(4);
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SIZE:   size_q <= pwdata[SIZE_W-1:0];
        REG_HASHES: hc_q   <= pwdata[HC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (size_q == '0) eff_size = SIZE_W'(1);
    else if (size_q > SIZE_W'(STORE_BYTES)) eff_size = SIZE_W'(STORE_BYTES);
    else eff_size = size_q;
    if (hc_q == '0) hc_clamp = HC_W'(1);
    else if (hc_q > HC_W'(MAX_HASHES)) hc_clamp = HC_W'(MAX_HASHES);
    else hc_clamp = hc_q;
    // a one-byte filter only has eight bits to hand out
    if (eff_size == SIZE_W'(1) && hc_clamp > HC_W'(8)) n_eff = HC_W'(8);
    else n_eff = hc_clamp;
  end

  always_comb begin
    cmd_d.op   = req_e'(in_item_i.req_type);
    cmd_d.hash = {in_item_i.hash_part_3, in_item_i.hash_part_2,
                  in_item_i.hash_part_1, in_item_i.hash_part_0};
    cmd_d.n    = n_eff;
    cmd_d.size = eff_size;
  end

  assign in_stall_o = cmd_vld_q & full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = cmd_vld_q & ~full_i;
  assign cmd_vld_d  = accept | (cmd_vld_q & full_i);
  assign cmd_o      = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
    end else begin
      cmd_vld_q <= cmd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

FILE: hdl/bfe_fifo.sv
// Two-entry command queue between front and back.
module bfe_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bfe_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output bfe_pkg::cmd_t data_o
);
  import bfe_pkg::*;

  cmd_t       ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/bfe_offsets.sv
// Bit offset generator: word-serial hash multiply and sorted insertion.
module bfe_offsets (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  bfe_pkg::cmd_t      cmd_i,
  output logic               done_o,
  output bfe_pkg::off_list_t list_o
);
  import bfe_pkg::*;

  typedef enum logic [3:0] {
    OG_IDLE = 4'b0001,
    OG_MUL  = 4'b0010,
    OG_FOLD = 4'b0100,
    OG_SORT = 4'b1000
  } og_state_e;

  og_state_e                    state_q;
  logic [HASH_WORDS-1:0][31:0]  work_q;
  logic [CNT_W-1:0]             bs_q, carry_q;
  logic [HC_W-1:0]              j_q, n_q, i_q;
  logic [$clog2(HASH_WORDS)-1:0] w_q;
  logic [OFF_W-1:0]             val_q;
  off_list_t                    list_q;
  logic                         done_q;

  logic [44:0]      prod;
  logic [32:0]      sum;
  logic [CNT_W-1:0] hi, lowbit, fold_mask;
  logic [HC_W-1:0]  nxt;
  logic             walk;

  assign prod      = 45'(work_q[w_q]) * 45'(bs_q);
  assign sum       = {1'b0, prod[31:0]} + 33'(carry_q);
  assign hi        = prod[44:32] + CNT_W'(sum[32]);
  assign lowbit    = bs_q & (~bs_q + CNT_W'(1));
  assign fold_mask = lowbit - CNT_W'(1);
  assign nxt       = i_q + HC_W'(1);
  assign walk      = (nxt < n_q) && (val_q >= list_q[nxt[HIDX_W-1:0]]);

  assign done_o = done_q;
  assign list_o = list_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= OG_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        OG_IDLE: if (start_i) state_q <= OG_MUL;
        OG_MUL:  if (w_q == '1) state_q <= OG_FOLD;
        OG_FOLD: state_q <= OG_SORT;
        OG_SORT: begin
          if (!walk) begin
            if (j_q == HC_W'(1)) begin
              state_q <= OG_IDLE;
              done_q  <= 1'b1;
            end else begin
              state_q <= OG_MUL;
            end
          end
        end
        default: state_q <= OG_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      OG_IDLE: begin
        if (start_i) begin
          work_q  <= cmd_i.hash;
          bs_q    <= {cmd_i.size, 3'b000};
          j_q     <= cmd_i.n;
          n_q     <= cmd_i.n;
          w_q     <= '0;
          carry_q <= '0;
        end
      end
      OG_MUL: begin
        work_q[w_q] <= sum[31:0];
        carry_q     <= hi;
        w_q         <= w_q + 1'b1;
      end
      OG_FOLD: begin
        // low carry bits lost by the multiply go back into word 0
        work_q[0] <= work_q[0] + 32'(carry_q & fold_mask);
        i_q       <= j_q - HC_W'(1);
        val_q     <= carry_q[OFF_W-1:0];
      end
      OG_SORT: begin
        if (walk) begin
          list_q[i_q[HIDX_W-1:0]] <= list_q[nxt[HIDX_W-1:0]];
          i_q   <= nxt;
          val_q <= val_q + OFF_W'(1);
        end else begin
          list_q[i_q[HIDX_W-1:0]] <= val_q;
          bs_q    <= bs_q - CNT_W'(1);
          j_q     <= j_q - HC_W'(1);
          w_q     <= '0;
          carry_q <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/bfe_back.sv
// Back end: bit store, insert/test/count sequencer and result register.
module bfe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  bfe_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bfe_pkg::out_item_t out_item_o
);
  import bfe_pkg::*;

  typedef enum logic [6:0] {
    BK_IDLE = 7'b0000001,
    BK_GEN  = 7'b0000010,
    BK_RD   = 7'b0000100,
    BK_CHK  = 7'b0001000,
    BK_CRD  = 7'b0010000,
    BK_CACC = 7'b0100000,
    BK_OUT  = 7'b1000000
  } bk_state_e;

  bk_state_e          state_q;
  req_e               op_q;
  logic [HC_W-1:0]    n_q;
  logic [SIZE_W-1:0]  size_q;
  logic [HIDX_W-1:0]  k_q;
  logic [OFF_W-1:0]   off_q;
  logic [ROW_AW-1:0]  r_q;
  logic               member_q;
  logic [CNT_W-1:0]   count_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic [ROW_BITS-1:0] mem_q [ROWS];
  logic [ROWS-1:0]     row_vld_q;
  logic [ROW_BITS-1:0] rd_data_q;
  logic                rd_vld_q;

  logic                start, gen_done, load_out, hit, in_range, last_k, last_r, we;
  logic [OFF_W-1:0]    cur_off;
  logic [ROW_AW-1:0]   ra;
  logic [ROW_BITS-1:0] data, wdata, cmask;
  logic [ROW_AW:0]     nrows;
  off_list_t           list;

  bfe_offsets u_offsets (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (cmd_i),
    .done_o  (gen_done),
    .list_o  (list)
  );

  assign pop_o    = (state_q == BK_IDLE) && !empty_i;
  assign start    = pop_o && (cmd_i.op == REQ_INSERT || cmd_i.op == REQ_TEST);
  assign cur_off  = list[k_q];
  assign ra       = (state_q == BK_RD) ? cur_off[OFF_W-1:5] : r_q;
  assign data     = rd_vld_q ? rd_data_q : '0;
  assign hit      = data[off_q[4:0]];
  assign in_range = {1'b0, off_q[OFF_W-1:3]} < size_q;
  assign wdata    = data | (ROW_BITS'(1) << off_q[4:0]);
  assign we       = (state_q == BK_CHK) && in_range && (op_q == REQ_INSERT);
  assign last_k   = {1'b0, k_q} == (n_q - HC_W'(1));
  assign nrows    = (ROW_AW+1)'((11'(size_q) + 11'd3) >> 2);
  assign last_r   = r_q == ROW_AW'(nrows - (ROW_AW+1)'(1));
  assign load_out = (state_q == BK_OUT) && (!out_valid_q || !out_stall_i);

  // only bytes below the active size count
  always_comb begin
    for (int b = 0; b < ROW_BITS / 8; b++) begin
      cmask[b*8 +: 8] = ({1'b0, r_q, 2'(b)} < size_q) ? data[b*8 +: 8] : 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[off_q[OFF_W-1:5]] <= wdata;
    rd_data_q <= mem_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (we) row_vld_q[off_q[OFF_W-1:5]] <= 1'b1;
      rd_vld_q <= row_vld_q[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        BK_IDLE: begin
          if (pop_o) begin
            if (start) state_q <= BK_GEN;
            else if (cmd_i.op == REQ_COUNT) state_q <= BK_CRD;
            else state_q <= BK_OUT;
          end
        end
        BK_GEN:  if (gen_done) state_q <= BK_RD;
        BK_RD:   state_q <= BK_CHK;
        BK_CHK:  state_q <= last_k ? BK_OUT : BK_RD;
        BK_CRD:  state_q <= BK_CACC;
        BK_CACC: state_q <= last_r ? BK_OUT : BK_CRD;
        BK_OUT:  if (load_out) state_q <= BK_IDLE;
        default: state_q <= BK_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BK_IDLE: begin
        if (pop_o) begin
          op_q     <= cmd_i.op;
          n_q      <= cmd_i.n;
          size_q   <= cmd_i.size;
          k_q      <= '0;
          r_q      <= '0;
          member_q <= 1'b1;
          count_q  <= '0;
        end
      end
      BK_RD: off_q <= cur_off;
      BK_CHK: begin
        if (!in_range || !hit) member_q <= 1'b0;
        k_q <= k_q + 1'b1;
      end
      BK_CACC: begin
        count_q <= count_q + CNT_W'($countones(cmask));
        r_q     <= r_q + 1'b1;
      end
      default: ;
    endcase
    if (load_out) begin
      out_q.is_member      <= (op_q == REQ_TEST) && member_q;
      out_q.bits_set_count <= (op_q == REQ_COUNT) ? count_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: tb/sv/tb_bloom_filter_engine.sv
// Self-checking testbench of the Bloom filter engine with its own bit-store predictor.
module tb_bloom_filter_engine;
  import bfe_pkg::*;

  localparam logic [2:0]  ADDR_SIZE   = 3'd0;
  localparam logic [2:0]  ADDR_HASHES = 3'd4;
  localparam int unsigned DRAIN_CYC   = 700;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_item_t    in_item_i;
  out_item_t   out_item_o;

  bloom_filter_engine u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .in_item_i, .out_valid_o, .out_stall_i, .out_item_o
  );

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // Predictor state: configuration and the bit store.
  logic [9:0]  cur_size_bytes = 10'd512;
  logic [4:0]  cur_hashes     = 5'd4;
  logic [7:0]  bit_store [STORE_BYTES];
  in_item_t    pending_items [$];
  out_item_t   expected_results [$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0, results_seen = 0;
  int unsigned n_insert = 0, n_test = 0, n_count = 0, n_none = 0, n_hits = 0;
  bit          calm = 1'b0;
  int unsigned hold_reqs = 0, hold_seen = 0, hold_left = 0;

  function automatic out_item_t predict_request(in_item_t it);
    logic [31:0] wh [HASH_WORDS];
    logic [11:0] offs [MAX_HASHES];
    out_item_t   res;
    int unsigned size, total, bs, n, i, tz, byte_i;
    logic [31:0] carry, hi, val;
    logic [63:0] prod;
    logic [32:0] sum;
    logic [255:0] hash;
    bit          all;
    res = '0;
    size = (cur_size_bytes == 0) ? 1 : (cur_size_bytes > STORE_BYTES ? STORE_BYTES
                                                                       : cur_size_bytes);
    case (req_e'(it.req_type))
      REQ_INSERT, REQ_TEST: begin
        total = size * 8;
        bs = total;
        n = (cur_hashes == 0) ? 1 : (cur_hashes > MAX_HASHES ? MAX_HASHES : cur_hashes);
        if (n > total) n = total;
        hash = {it.hash_part_3, it.hash_part_2, it.hash_part_1, it.hash_part_0};
        for (int w = 0; w < HASH_WORDS; w++) wh[w] = hash[32*w +: 32];
        for (int k = 0; k < MAX_HASHES; k++) offs[k] = '0;
        for (int j = n; j > 0; j--) begin
          carry = '0;
          for (int w = 0; w < HASH_WORDS; w++) begin
            prod = 64'(wh[w]) * 64'(bs);
            hi = prod[63:32];
            sum = {1'b0, prod[31:0]} + {1'b0, carry};
            if (sum[32]) hi = hi + 1;
            wh[w] = sum[31:0];
            carry = hi;
          end
          tz = 0;
          while (tz < 31 && bs[tz] == 1'b0) tz++;
          // low carry bits lost by the multiply go back into word 0
          if (tz >= 1) wh[0] = wh[0] + (carry & ((32'd1 << tz) - 1));
          i = j - 1;
          val = carry;
          while (i + 1 < n && val >= 32'(offs[i+1])) begin
            offs[i] = offs[i+1];
            i++;
            val++;
          end
          offs[i] = val[11:0];
          bs--;
        end
        all = 1'b1;
        for (int k = 0; k < n; k++) begin
          byte_i = offs[k] >> 3;
          if (byte_i >= size) begin
            all = 1'b0;
          end else if (req_e'(it.req_type) == REQ_INSERT) begin
            bit_store[byte_i][offs[k][2:0]] = 1'b1;
          end else if (!bit_store[byte_i][offs[k][2:0]]) begin
            all = 1'b0;
          end
        end
        if (req_e'(it.req_type) == REQ_TEST) begin
          res.is_member = all;
          n_test++;
          if (all) n_hits++;
        end else begin
          n_insert++;
        end
      end
      REQ_COUNT: begin
        for (int b = 0; b < size; b++) res.bits_set_count += $countones(bit_store[b]);
        n_count++;
      end
      default: n_none++;
    endcase
    return res;
  endfunction

  // Sender: next item loaded once the current one is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        expected_results.push_back(predict_request(in_item_i));
        items_sent++;
      end
      if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 35)) begin
        in_item_i  <= pending_items.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall, with a long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen   = hold_reqs;
      hold_left   = 400;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 35);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", out_item_o);
      end else begin
        out_item_t exp_r;
        exp_r = expected_results.pop_front();
        if (out_item_o.is_member !== exp_r.is_member ||
            out_item_o.bits_set_count !== exp_r.bits_set_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: member exp %0b got %0b, count exp %0d got %0d",
                     results_seen, exp_r.is_member, out_item_o.is_member,
                     exp_r.bits_set_count, out_item_o.bits_set_count);
        end
      end
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_SIZE) cur_size_bytes = data[9:0];
    else if (addr == ADDR_HASHES) cur_hashes = data[4:0];
  endtask

  task automatic wait_idle();
    wait (pending_items.size() == 0 && !in_valid_i && expected_results.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  function automatic in_item_t make_item(input req_e op, input int unsigned shape);
    in_item_t it;
    it.req_type = op;
    case (shape)
      0: {it.hash_part_3, it.hash_part_2, it.hash_part_1, it.hash_part_0} = '0;
      1: {it.hash_part_3, it.hash_part_2, it.hash_part_1, it.hash_part_0} = '1;
      default: begin
        it.hash_part_0 = {$urandom, $urandom};
        it.hash_part_1 = {$urandom, $urandom};
        it.hash_part_2 = {$urandom, $urandom};
        it.hash_part_3 = {$urandom, $urandom};
      end
    endcase
    return it;
  endfunction

  // Mostly inserts and tests; tests often repeat an earlier inserted hash.
  task automatic queue_random(input int unsigned count);
    in_item_t recent [$];
    in_item_t it;
    int unsigned r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        it = make_item(REQ_INSERT, ($urandom_range(19) == 0) ? $urandom_range(1) : 2);
        recent.push_back(it);
      end else if (r < 80) begin
        if (recent.size() > 0 && $urandom_range(1)) begin
          it = recent[$urandom_range(recent.size() - 1)];
          it.req_type = REQ_TEST;
        end else begin
          it = make_item(REQ_TEST, 2);
        end
      end else if (r < 95) begin
        it = make_item(REQ_COUNT, 2);
      end else begin
        it = make_item(REQ_NONE, 2);
      end
      pending_items.push_back(it);
    end
  endtask

  task automatic queue_directed();
    in_item_t it;
    pending_items.push_back(make_item(REQ_COUNT, 2));
    pending_items.push_back(make_item(REQ_TEST, 0));
    pending_items.push_back(make_item(REQ_INSERT, 0));
    pending_items.push_back(make_item(REQ_TEST, 0));
    pending_items.push_back(make_item(REQ_INSERT, 1));
    pending_items.push_back(make_item(REQ_TEST, 1));
    pending_items.push_back(make_item(REQ_COUNT, 1));
    pending_items.push_back(make_item(REQ_NONE, 1));
    pending_items.push_back(make_item(REQ_NONE, 0));
    it = make_item(REQ_INSERT, 2);
    pending_items.push_back(it);
    it.req_type = REQ_TEST;
    pending_items.push_back(it);
    pending_items.push_back(make_item(REQ_TEST, 2));
    pending_items.push_back(make_item(REQ_COUNT, 0));
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    for (int b = 0; b < STORE_BYTES; b++) bit_store[b] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration: full size, four hashes
    queue_directed();
    wait_idle();
    queue_random(150);
    wait_idle();
    // smallest filter, most hashes: count capped at the bit count
    reg_write(ADDR_SIZE, 1);
    reg_write(ADDR_HASHES, 16);
    queue_directed();
    queue_random(80);
    wait_idle();
    // out-of-range values: zero size and zero hashes
    reg_write(ADDR_SIZE, 0);
    reg_write(ADDR_HASHES, 0);
    queue_directed();
    queue_random(60);
    wait_idle();
    // above range, then grow back over untouched bytes
    reg_write(ADDR_SIZE, 32'h3ff);
    reg_write(ADDR_HASHES, 32'h1f);
    queue_directed();
    queue_random(50);
    wait_idle();
    reg_write(ADDR_SIZE, 24);
    reg_write(ADDR_HASHES, 3);
    calm = 1'b1;
    queue_random(300);
    wait_idle();
    calm = 1'b0;
    reg_write(ADDR_SIZE, 37);
    reg_write(ADDR_HASHES, 5);
    queue_random(100);
    // long receiver hold-off while items keep coming
    hold_reqs++;
    wait_idle();
    reg_write(ADDR_SIZE, 8);
    reg_write(ADDR_HASHES, 2);
    queue_random(350);
    wait_idle();
    reg_write(ADDR_SIZE, 200);
    reg_write(ADDR_HASHES, 1);
    queue_random(300);
    wait_idle();
    reg_write(ADDR_SIZE, 512);
    reg_write(ADDR_HASHES, 16);
    queue_random(60);
    wait_idle();
    reg_write(ADDR_SIZE, 3);
    reg_write(ADDR_HASHES, 7);
    queue_random(130);
    wait_idle();

    $display("covered %0d items: %0d inserts, %0d tests (%0d hits), %0d counts, %0d unknown",
             items_sent, n_insert, n_test, n_hits, n_count, n_none);
    $display("sizes 0..1023 and hash counts 0..31 written, %0d mismatches", mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_bloom_filter_engine: PASS");
    end else begin
      $display("tb_bloom_filter_engine: FAIL");
    end
    $finish;
  end

  initial begin
    #(4 * 4000000);
    $display("timeout: %0d results outstanding", expected_results.size());
    $display("tb_bloom_filter_engine: FAIL");
    $finish;
  end

endmodule

FILE: bloom_filter_engine.f
hdl/bfe_pkg.sv
hdl/bfe_front.sv
hdl/bfe_fifo.sv
hdl/bfe_offsets.sv
hdl/bfe_back.sv
hdl/bloom_filter_engine.sv
tb/sv/tb_bloom_filter_engine.sv
